@@ rtl/bmp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared types and constants for the BMP 24-bit to RGB565 blit block.
// ----------------------------------------------------------------------------
package bmp_pkg;

   localparam int REG_WIDTH   = 12;
   localparam int ADDR_WIDTH  = 22;
   localparam int PIX_WIDTH   = 16;
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;
   localparam int QUEUE_DEPTH = 4;

   // register indexes
   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd2;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

   // byte positions within a pixel
   localparam logic [1:0] PHASE_BLUE  = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_RED   = 2'd2;

   localparam logic [7:0] MASK_RED_BLUE = 8'hf8;
   localparam logic [7:0] MASK_GREEN    = 8'hfc;
   localparam logic [1:0] MASK_PAD      = 2'h3;

   // geometry seen by the byte parser
   typedef struct packed {
      logic                   ok;
      logic [ADDR_WIDTH-1:0]  base;
      logic [REG_WIDTH-1:0]   image_width;
      logic [REG_WIDTH-1:0]   image_height;
      logic [REG_WIDTH-1:0]   screen_width;
   } bmp_geom_type;

   // one assembled pixel on its way to the output stage
   typedef struct packed {
      logic [7:0]             red;
      logic [7:0]             green;
      logic [7:0]             blue;
      logic [ADDR_WIDTH-1:0]  base;
      logic [REG_WIDTH-1:0]   column;
      logic                   last;
   } bmp_pixel_type;

endpackage
`default_nettype wire

@@ rtl/bmp_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_csr
// Geometry registers on the APB-style port, plus a two-stage pipeline that
// checks the geometry and works out the address of the bottom image row.
// ----------------------------------------------------------------------------
module bmp_csr #(
   parameter int MAX_DIMENSION = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bmp_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [bmp_pkg::CSR_DW-1:0]    csr_pwdata,
   output      logic [bmp_pkg::CSR_DW-1:0]    csr_prdata,
   output      logic                          csr_pready,
   output      bmp_pkg::bmp_geom_type         geom,
   output      logic                          settling
);
   import bmp_pkg::*;

   logic [REG_WIDTH-1:0]  img_w_ff, img_w_in, img_h_ff, img_h_in;
   logic [REG_WIDTH-1:0]  scr_w_ff, scr_w_in, scr_h_ff, scr_h_in;
   logic                  wr_en;
   logic [1:0]            reg_idx;
   logic [REG_WIDTH-1:0]  rd_val;

   logic                  ok1_ff, ok1_in, ok2_ff, ok2_in;
   logic [REG_WIDTH-1:0]  rows1_ff, rows1_in, col1_ff, col1_in;
   logic [ADDR_WIDTH-1:0] base2_ff, base2_in;
   logic [2*REG_WIDTH-1:0] product;
   logic [1:0]            settle_ff, settle_in;

   function automatic logic dim_ok(input logic [REG_WIDTH-1:0] v);
      return (v != '0) && (32'(v) <= MAX_DIMENSION);
   endfunction

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      img_w_in = img_w_ff;
      img_h_in = img_h_ff;
      scr_w_in = scr_w_ff;
      scr_h_in = scr_h_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_IMAGE_WIDTH:   img_w_in = csr_pwdata[REG_WIDTH-1:0];
            REG_IMAGE_HEIGHT:  img_h_in = csr_pwdata[REG_WIDTH-1:0];
            REG_SCREEN_WIDTH:  scr_w_in = csr_pwdata[REG_WIDTH-1:0];
            REG_SCREEN_HEIGHT: scr_h_in = csr_pwdata[REG_WIDTH-1:0];
            default:           img_w_in = img_w_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:   rd_val = img_w_ff;
         REG_IMAGE_HEIGHT:  rd_val = img_h_ff;
         REG_SCREEN_WIDTH:  rd_val = scr_w_ff;
         REG_SCREEN_HEIGHT: rd_val = scr_h_ff;
         default:           rd_val = '0;
      endcase
      csr_prdata = CSR_DW'(rd_val);
   end

   // stage 1: range checks, centring offsets
   always_comb begin
      ok1_in = dim_ok(img_w_ff) && dim_ok(img_h_ff) && dim_ok(scr_w_ff) &&
               dim_ok(scr_h_ff) && (img_w_ff <= scr_w_ff) && (img_h_ff <= scr_h_ff);
      rows1_in = img_h_ff - 1'b1 + ((scr_h_ff - img_h_ff) >> 1);
      col1_in  = (scr_w_ff - img_w_ff) >> 1;
   end

   // stage 2: row times stride plus column
   always_comb begin
      product  = rows1_ff * scr_w_ff;
      base2_in = product[ADDR_WIDTH-1:0] + ADDR_WIDTH'(col1_ff);
      ok2_in   = ok1_ff;
   end

   // hold off input until the pipeline reflects the last write
   always_comb begin
      if (wr_en) begin
         settle_in = 2'd2;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= REG_WIDTH'(1);
         img_h_ff  <= REG_WIDTH'(1);
         scr_w_ff  <= REG_WIDTH'(1024);
         scr_h_ff  <= REG_WIDTH'(768);
         settle_ff <= 2'd2;
      end else begin
         img_w_ff  <= img_w_in;
         img_h_ff  <= img_h_in;
         scr_w_ff  <= scr_w_in;
         scr_h_ff  <= scr_h_in;
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      ok1_ff   <= ok1_in;
      rows1_ff <= rows1_in;
      col1_ff  <= col1_in;
      ok2_ff   <= ok2_in;
      base2_ff <= base2_in;
   end

   assign settling          = (settle_ff != 2'd0);
   assign geom.ok           = ok2_ff;
   assign geom.base         = base2_ff;
   assign geom.image_width  = img_w_ff;
   assign geom.image_height = img_h_ff;
   assign geom.screen_width = scr_w_ff;

endmodule
`default_nettype wire

@@ rtl/bmp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_front
// Byte parser: tracks byte phase, row padding and position, and hands each
// complete pixel with its row base and column to the queue.
// ----------------------------------------------------------------------------
module bmp_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   first_byte,
   input  wire bmp_pkg::bmp_geom_type  geom,
   output      logic                   pix_valid,
   output      bmp_pkg::bmp_pixel_type pix
);
   import bmp_pkg::*;

   logic [1:0]            phase_ff, phase_in, phase;
   logic [15:0]           held_ff, held_in, held;
   logic [REG_WIDTH-1:0]  col_ff, col_in, col;
   logic [REG_WIDTH-1:0]  row_ff, row_in, row;
   logic [1:0]            pad_ff, pad_in, pad;
   logic [ADDR_WIDTH-1:0] base_ff, base_in, base;
   logic                  big_ff, big_in, big;
   logic [REG_WIDTH:0]    col_next, row_next;
   logic                  emit;

   always_comb begin
      phase = phase_ff;
      held  = held_ff;
      col   = col_ff;
      row   = row_ff;
      pad   = pad_ff;
      base  = base_ff;
      big   = big_ff;
      if (first_byte) begin
         phase = PHASE_BLUE;
         held  = '0;
         col   = '0;
         row   = '0;
         pad   = '0;
         big   = !geom.ok;
         base  = geom.ok ? geom.base : '0;
      end

      col_next = {1'b0, col} + 1'b1;
      row_next = {1'b0, row} + 1'b1;
      emit     = 1'b0;
      pix.red    = data_byte;
      pix.green  = held[15:8];
      pix.blue   = held[7:0];
      pix.base   = base;
      pix.column = col;
      pix.last   = (row_next >= {1'b0, geom.image_height}) &&
                   (col_next >= {1'b0, geom.image_width});

      phase_in = phase;
      held_in  = held;
      col_in   = col;
      row_in   = row;
      pad_in   = pad;
      base_in  = base;
      big_in   = big;

      if (big || (row >= geom.image_height)) begin
         // image rejected or finished: drop the byte
         emit = 1'b0;
      end else if (pad != 2'd0) begin
         pad_in = pad - 2'd1;
      end else begin
         case (phase)
            PHASE_BLUE: begin
               held_in[7:0] = data_byte;
               phase_in     = PHASE_GREEN;
            end
            PHASE_GREEN: begin
               held_in[15:8] = data_byte;
               phase_in      = PHASE_RED;
            end
            default: begin
               emit     = 1'b1;
               phase_in = PHASE_BLUE;
               if (col_next >= {1'b0, geom.image_width}) begin
                  col_in  = '0;
                  row_in  = row_next[REG_WIDTH-1:0];
                  base_in = base - ADDR_WIDTH'(geom.screen_width);
                  pad_in  = geom.image_width[1:0] & MASK_PAD;
               end else begin
                  col_in  = col_next[REG_WIDTH-1:0];
               end
            end
         endcase
      end
   end

   assign pix_valid = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_BLUE;
         held_ff  <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         pad_ff   <= '0;
         base_ff  <= '0;
         big_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pad_ff   <= pad_in;
         base_ff  <= base_in;
         big_ff   <= big_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/bmp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_queue
// Short pixel queue between the byte parser and the output stage.
// ----------------------------------------------------------------------------
module bmp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire bmp_pkg::bmp_pixel_type push_data,
   input  wire logic                   pop,
   output      bmp_pkg::bmp_pixel_type head,
   output      logic                   not_empty,
   output      logic                   full
);
   import bmp_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   bmp_pixel_type mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/bmp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_back
// Output stage: packs the colour bytes to RGB565, adds the column to the row
// base and holds the result until it is popped.
// ----------------------------------------------------------------------------
module bmp_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_not_empty,
   input  wire bmp_pkg::bmp_pixel_type       q_head,
   output      logic                         q_pop,
   input  wire logic                         rsp_pop,
   output      logic                         rsp_empty,
   output      logic [bmp_pkg::ADDR_WIDTH-1:0] rsp_fb_address,
   output      logic [bmp_pkg::PIX_WIDTH-1:0]  rsp_pixel565,
   output      logic                         rsp_last_pixel
);
   import bmp_pkg::*;

   logic                  valid_ff, valid_in;
   logic [ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [PIX_WIDTH-1:0]  pix_ff, pix_in;
   logic                  last_ff, last_in;
   logic [7:0]            r, g, b;

   assign q_pop = q_not_empty && (!valid_ff || rsp_pop);

   always_comb begin
      r       = q_head.red   & MASK_RED_BLUE;
      g       = q_head.green & MASK_GREEN;
      b       = q_head.blue  & MASK_RED_BLUE;
      pix_in  = {r[7:3], g[7:2], b[7:3]};
      addr_in = q_head.base + ADDR_WIDTH'(q_head.column);
      last_in = q_head.last;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         addr_ff <= addr_in;
         pix_ff  <= pix_in;
         last_ff <= last_in;
      end
   end

   assign rsp_empty      = !valid_ff;
   assign rsp_fb_address = addr_ff;
   assign rsp_pixel565   = pix_ff;
   assign rsp_last_pixel = last_ff;

endmodule
`default_nettype wire

@@ rtl/bmp24_to_rgb565_blit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_to_rgb565_blit
// Bottom-up 24-bit BMP pixel bytes to centred RGB565 framebuffer writes.
// ----------------------------------------------------------------------------
// Takes one pixel-data byte per clock while req_full is low and yields one
// result per three pixel bytes (padding skipped), so the sustained rate is
// one byte per cycle. A byte goes through the parser, a four-entry queue and
// an output register: a pixel enters the queue with its red byte and the
// output register when free. The row base comes from a two-stage multiply
// pipeline on the geometry registers; after reset and after every register
// write, req_full stays high while that pipeline settles. req_full also rises
// when the queue is full. Images larger than the screen, or with a dimension of
// zero or above MAX_DIMENSION, produce no results until the next first_byte.
// ----------------------------------------------------------------------------
module bmp24_to_rgb565_blit #(
   parameter int MAX_DIMENSION = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output      logic                              req_full,
   input  wire logic [7:0]                        req_data_byte,
   input  wire logic                              req_first_byte,
   output      logic                              rsp_empty,
   input  wire logic                              rsp_pop,
   output      logic [bmp_pkg::ADDR_WIDTH-1:0]    rsp_fb_address,
   output      logic [bmp_pkg::PIX_WIDTH-1:0]     rsp_pixel565,
   output      logic                              rsp_last_pixel,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bmp_pkg::CSR_AW-1:0]        csr_paddr,
   input  wire logic [bmp_pkg::CSR_DW-1:0]        csr_pwdata,
   output      logic [bmp_pkg::CSR_DW-1:0]        csr_prdata,
   output      logic                              csr_pready
);
   import bmp_pkg::*;

   bmp_geom_type  geom;
   bmp_pixel_type front_pix, q_head;
   logic          settling, accept, front_valid;
   logic          q_full, q_not_empty, q_pop;

   assign req_full = settling || q_full;
   assign accept   = req_push && !req_full;

   bmp_csr #(.MAX_DIMENSION(MAX_DIMENSION)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .geom        (geom),
      .settling    (settling)
   );

   bmp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .first_byte (req_first_byte),
      .geom       (geom),
      .pix_valid  (front_valid),
      .pix        (front_pix)
   );

   bmp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_pix),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   bmp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_fb_address (rsp_fb_address),
      .rsp_pixel565   (rsp_pixel565),
      .rsp_last_pixel (rsp_last_pixel)
   );

endmodule
`default_nettype wire

@@ rtl/bmp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_checker
// Port-level checks for the blit block, bound to the top level.
// ----------------------------------------------------------------------------
module bmp_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_full,
   input wire logic                           rsp_empty,
   input wire logic                           rsp_pop,
   input wire logic [bmp_pkg::ADDR_WIDTH-1:0] rsp_fb_address,
   input wire logic [bmp_pkg::PIX_WIDTH-1:0]  rsp_pixel565,
   input wire logic                           rsp_last_pixel,
   input wire logic                           csr_psel,
   input wire logic                           csr_penable,
   input wire logic                           csr_pwrite,
   input wire logic                           csr_pready
);

   // reset empties the result side and holds input while geometry settles
   a_reset_state: assert property (@(posedge clock)
      reset |=> (rsp_empty && req_full))
      else $error("block not empty and blocked after reset");

   // a register write holds off input for the geometry pipeline
   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite) |=> req_full)
      else $error("input taken right after a register write");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("pready dropped");

   // a waiting item holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_fb_address) &&
         $stable(rsp_pixel565) && $stable(rsp_last_pixel)))
      else $error("result changed while stalled");

endmodule

bind bmp24_to_rgb565_blit bmp_checker u_bmp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_fb_address (rsp_fb_address),
   .rsp_pixel565   (rsp_pixel565),
   .rsp_last_pixel (rsp_last_pixel),
   .csr_psel       (csr_psel),
   .csr_penable    (csr_penable),
   .csr_pwrite     (csr_pwrite),
   .csr_pready     (csr_pready)
);
`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Checks the BMP 24-bit to RGB565 blit against an in-bench prediction.
// ----------------------------------------------------------------------------
// The stimulus is a stream of BMP pixel bytes. A directed part covers
// addresses that wrap, colour masks, row padding, bytes after the image and
// an image wider than the screen. Random phases follow, each one starting
// with register writes while the block is idle. Each byte the block takes is
// run through a local copy of the blit state. Every predicted framebuffer
// write is queued and then compared field by field with what the block pops.
// Bytes arrive in bursts with gaps, and the result side stalls in changing
// patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import bmp_pkg::*;

   localparam int          MAX_DIMENSION = 2048;
   localparam int          IDLE_LIMIT    = 4000;
   localparam int          IMAGE_CAP     = 180;
   localparam int          TARGET_BYTES  = 1800;
   localparam int          DRAIN_CYCLES  = 8;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } bmp_byte_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] fb_address;
      logic [PIX_WIDTH-1:0]  pixel565;
      logic                  last_pixel;
   } fb_write_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic [7:0]            req_data_byte;
   logic                  req_first_byte;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic [ADDR_WIDTH-1:0] rsp_fb_address;
   logic [PIX_WIDTH-1:0]  rsp_pixel565;
   logic                  rsp_last_pixel;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_AW-1:0]     csr_paddr;
   logic [CSR_DW-1:0]     csr_pwdata;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   bmp24_to_rgb565_blit dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_first_byte (req_first_byte),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_fb_address (rsp_fb_address),
      .rsp_pixel565   (rsp_pixel565),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #5 clock = ~clock;

   bmp_byte_type          bmp_bytes[$];
   fb_write_type          predicted_writes[$];
   int                    mismatches = 0;
   bit                    byte_taken = 0;
   int                    idle_cycles = 0;

   // live register copy and blit state
   logic [REG_WIDTH-1:0]  geom_reg [4];
   logic [1:0]            px_phase;
   logic [15:0]           px_held;
   int unsigned           px_column;
   int unsigned           px_row;
   logic [1:0]            px_pad;
   logic [ADDR_WIDTH-1:0] px_row_base;
   bit                    px_too_large;

   function automatic void note_failure(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("%s", msg);
   endfunction

   function automatic bit geometry_ok();
      int unsigned w, h, sw, sh;
      w  = geom_reg[REG_IMAGE_WIDTH];
      h  = geom_reg[REG_IMAGE_HEIGHT];
      sw = geom_reg[REG_SCREEN_WIDTH];
      sh = geom_reg[REG_SCREEN_HEIGHT];
      return w >= 1 && w <= MAX_DIMENSION && h >= 1 && h <= MAX_DIMENSION &&
             sw >= 1 && sw <= MAX_DIMENSION && sh >= 1 && sh <= MAX_DIMENSION &&
             w <= sw && h <= sh;
   endfunction

   function automatic void predict_blit_byte(input logic [7:0] data, input logic first);
      int unsigned  w, h, sw, sh;
      fb_write_type wr;
      w  = geom_reg[REG_IMAGE_WIDTH];
      h  = geom_reg[REG_IMAGE_HEIGHT];
      sw = geom_reg[REG_SCREEN_WIDTH];
      sh = geom_reg[REG_SCREEN_HEIGHT];
      if (first) begin
         px_phase  = PHASE_BLUE;
         px_held   = '0;
         px_column = 0;
         px_row    = 0;
         px_pad    = '0;
         if (!geometry_ok()) begin
            px_too_large = 1'b1;
            px_row_base  = '0;
         end else begin
            px_too_large = 1'b0;
            // bottom image row of a centred image
            px_row_base  = ADDR_WIDTH'((h - 1 + (sh - h) / 2) * sw + (sw - w) / 2);
         end
      end
      if (px_too_large || px_row >= h)
         return;
      if (px_pad != 0) begin
         px_pad = px_pad - 1'b1;
         return;
      end
      case (px_phase)
         PHASE_BLUE: begin
            px_held[7:0] = data;
            px_phase     = PHASE_GREEN;
            return;
         end
         PHASE_GREEN: begin
            px_held[15:8] = data;
            px_phase      = PHASE_RED;
            return;
         end
         default: ;
      endcase
      wr.pixel565   = {data[7:3], px_held[15:10], px_held[7:3]};
      wr.fb_address = ADDR_WIDTH'(px_row_base + px_column);
      wr.last_pixel = (px_row + 1 >= h) && (px_column + 1 >= w);
      predicted_writes.push_back(wr);
      px_phase  = PHASE_BLUE;
      px_column = px_column + 1;
      if (px_column >= w) begin
         px_column   = 0;
         px_row      = px_row + 1;
         px_row_base = ADDR_WIDTH'(px_row_base - sw);
         px_pad      = w[1:0] & MASK_PAD;
      end
   endfunction

   // input side: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin
      logic next_push;
      next_push = 1'b0;
      if (byte_taken) begin
         bmp_bytes.delete(0);
         byte_taken = 0;
      end
      if (gap_left > 0) begin
         gap_left--;
      end else if (bmp_bytes.size() != 0 && !reset) begin
         next_push = 1'b1;
         req_data_byte  <= bmp_bytes[0].data;
         req_first_byte <= bmp_bytes[0].first;
         if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
      req_push <= next_push;
   end

   // result side: the stall pattern is picked anew at random from four modes
   int rx_mode  = 0;
   int rx_left  = 0;
   int rx_tick  = 0;

   always @(negedge clock) begin
      logic pop;
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(64, 256);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         0:       pop = 1'b1;
         1:       pop = $urandom_range(0, 1);
         2:       pop = (rx_tick % 4) == 0;
         default: pop = (rx_tick % 30) >= 20;
      endcase
      rsp_pop <= pop;
   end

   always @(posedge clock) begin : monitor
      fb_write_type got, want;
      bit           progress;
      progress = 1'b0;
      if (!reset) begin
         byte_taken = req_push && !req_full;
         if (byte_taken) begin
            predict_blit_byte(req_data_byte, req_first_byte);
            progress = 1'b1;
         end
         if (!rsp_empty && rsp_pop) begin
            progress = 1'b1;
            got = '{rsp_fb_address, rsp_pixel565, rsp_last_pixel};
            if (predicted_writes.size() == 0) begin
               note_failure($sformatf("unexpected item: fb_address %h pixel565 %h last %b",
                                      got.fb_address, got.pixel565, got.last_pixel));
            end else begin
               want = predicted_writes.pop_front();
               if (got.fb_address !== want.fb_address)
                  note_failure($sformatf("fb_address: expected %h, got %h",
                                         want.fb_address, got.fb_address));
               if (got.pixel565 !== want.pixel565)
                  note_failure($sformatf("pixel565 at %h: expected %h, got %h",
                                         want.fb_address, want.pixel565, got.pixel565));
               if (got.last_pixel !== want.last_pixel)
                  note_failure($sformatf("last_pixel at %h: expected %b, got %b",
                                         want.fb_address, want.last_pixel, got.last_pixel));
            end
         end
         if (csr_psel && csr_penable)
            progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [REG_WIDTH-1:0] value);
      logic [CSR_DW-1:0] word;
      logic [CSR_DW-1:0] readback;
      // upper data bits are junk now and then; only the low 12 bits count
      word = ($urandom_range(0, 3) == 0) ? CSR_DW'($urandom()) : '0;
      word[REG_WIDTH-1:0] = value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      geom_reg[idx] = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      if (readback !== CSR_DW'(value))
         note_failure($sformatf("register %0d readback: expected %h, got %h",
                                idx, CSR_DW'(value), readback));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic wait_idle();
      while (bmp_bytes.size() != 0 || predicted_writes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void push_byte(input logic [7:0] data, input logic first);
      bmp_byte_type b;
      b.data  = data;
      b.first = first;
      bmp_bytes.push_back(b);
   endfunction

   function automatic void pick_geometry(input int phase_no,
                                         output logic [REG_WIDTH-1:0] geom[4]);
      int unsigned w, h, sw, sh, sel;
      sel = $urandom_range(0, 99);
      w   = $urandom_range(1, 12);
      h   = $urandom_range(1, 6);
      sw  = $urandom_range(w, w + 40);
      sh  = $urandom_range(h, h + 30);
      if (phase_no == 0) begin
         w = MAX_DIMENSION; h = MAX_DIMENSION; sw = MAX_DIMENSION; sh = MAX_DIMENSION;
      end else if (phase_no == 1) begin
         w = 1; h = 1; sw = 1; sh = 1;
      end else if (sel < 6) begin
         w  = $urandom_range(1000, MAX_DIMENSION);
         sw = $urandom_range(w, MAX_DIMENSION);
         h  = $urandom_range(1, 4);
         sh = $urandom_range(h, 768);
      end else if (sel < 12) begin
         h  = $urandom_range(500, MAX_DIMENSION);
         sh = $urandom_range(h, MAX_DIMENSION);
         w  = $urandom_range(1, 8);
         sw = $urandom_range(w, MAX_DIMENSION);
      end else if (sel < 20) begin
         sw = $urandom_range(w, MAX_DIMENSION);
         sh = $urandom_range(h, MAX_DIMENSION);
      end
      geom[REG_IMAGE_WIDTH]   = REG_WIDTH'(w);
      geom[REG_IMAGE_HEIGHT]  = REG_WIDTH'(h);
      geom[REG_SCREEN_WIDTH]  = REG_WIDTH'(sw);
      geom[REG_SCREEN_HEIGHT] = REG_WIDTH'(sh);
      // bad geometry: zero, above the limit, or image larger than the screen
      if (phase_no == 2) begin
         geom[REG_SCREEN_WIDTH] = '0;
      end else if (phase_no == 3) begin
         geom[REG_IMAGE_HEIGHT] = '1;
      end else if (phase_no > 3 && sel >= 88) begin
         case ($urandom_range(0, 3))
            0: geom[$urandom_range(0, 3)] = '0;
            1: geom[$urandom_range(0, 3)] = REG_WIDTH'($urandom_range(MAX_DIMENSION + 1, 4095));
            2: geom[REG_IMAGE_WIDTH]  = REG_WIDTH'(sw + $urandom_range(1, 3));
            default: geom[REG_IMAGE_HEIGHT] = REG_WIDTH'(sh + $urandom_range(1, 3));
         endcase
      end
   endfunction

   initial begin
      logic [REG_WIDTH-1:0] geom[4];
      int unsigned          fed, w, h, full, count, phase_no, n_images;
      bit                   good, set_first;

      reset          = 1'b1;
      req_push       = 1'b0;
      req_data_byte  = '0;
      req_first_byte = 1'b0;
      rsp_pop        = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;

      geom_reg[REG_IMAGE_WIDTH]   = 12'd1;
      geom_reg[REG_IMAGE_HEIGHT]  = 12'd1;
      geom_reg[REG_SCREEN_WIDTH]  = 12'd1024;
      geom_reg[REG_SCREEN_HEIGHT] = 12'd768;
      px_phase     = PHASE_BLUE;
      px_held      = '0;
      px_column    = 0;
      px_row       = 0;
      px_pad       = '0;
      px_row_base  = '0;
      px_too_large = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no first byte yet: base starts at zero and the next row wraps
      csr_write(REG_IMAGE_HEIGHT, 12'd2);
      push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b0); push_byte(8'hff, 1'b0);
      push_byte(8'haa, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'h55, 1'b0);
      wait_idle();

      // 2x2 image centred on a 5x3 screen, two pad bytes per row
      csr_write(REG_IMAGE_WIDTH, 12'd2);
      csr_write(REG_SCREEN_WIDTH, 12'd5);
      csr_write(REG_SCREEN_HEIGHT, 12'd3);
      push_byte(8'h07, 1'b1); push_byte(8'h03, 1'b0); push_byte(8'hf8, 1'b0);
      push_byte(8'hf8, 1'b0); push_byte(8'hfc, 1'b0); push_byte(8'h07, 1'b0);
      push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b0);
      push_byte(8'hff, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0);
      push_byte(8'h00, 1'b0); push_byte(8'hff, 1'b0); push_byte(8'h7f, 1'b0);
      push_byte(8'h33, 1'b0); push_byte(8'h44, 1'b0);
      push_byte(8'hc3, 1'b0);
      wait_idle();

      // wider than the screen: nothing comes out
      csr_write(REG_IMAGE_WIDTH, 12'd6);
      push_byte(8'h12, 1'b1); push_byte(8'h34, 1'b0); push_byte(8'h56, 1'b0);
      wait_idle();

      fed      = 0;
      phase_no = 0;
      while (fed < TARGET_BYTES) begin
         pick_geometry(phase_no, geom);
         for (int i = REG_IMAGE_WIDTH; i <= REG_SCREEN_HEIGHT; i++)
            if (phase_no < 4 || $urandom_range(0, 4) != 0)
               csr_write(i[1:0], geom[i]);
         good     = geometry_ok();
         w        = geom_reg[REG_IMAGE_WIDTH];
         h        = geom_reg[REG_IMAGE_HEIGHT];
         n_images = $urandom_range(1, 3);
         for (int img = 0; img < n_images; img++) begin
            if (!good) begin
               count = $urandom_range(2, 12);
               for (int k = 0; k < count; k++)
                  push_byte(rand_byte(), k == 0);
               continue;
            end
            // stray bytes ahead of the image, now and then a restart among them
            if ($urandom_range(0, 9) == 0) begin
               count = $urandom_range(1, 5);
               for (int k = 0; k < count; k++)
                  push_byte(rand_byte(), $urandom_range(0, 7) == 0);
               fed += count;
            end
            full  = h * (3 * w + (w & 3));
            count = (full > IMAGE_CAP) ? IMAGE_CAP : full;
            if ($urandom_range(0, 9) == 0)
               count = $urandom_range(1, count);
            // the first image of a phase sometimes carries on the previous one
            set_first = img > 0 || $urandom_range(0, 9) != 0;
            for (int k = 0; k < count; k++)
               push_byte(rand_byte(), k == 0 && set_first);
            fed += count;
            if (count == full) begin
               count = $urandom_range(0, 3);
               for (int k = 0; k < count; k++)
                  push_byte(rand_byte(), 1'b0);
               fed += count;
            end
         end
         wait_idle();
         phase_no++;
      end

      wait_idle();
      if (mismatches == 0 && predicted_writes.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
rtl/bmp_pkg.sv
rtl/bmp_csr.sv
rtl/bmp_front.sv
rtl/bmp_queue.sv
rtl/bmp_back.sv
rtl/bmp24_to_rgb565_blit.sv
rtl/bmp_checker.sv
bench/tb_top.sv
